>>> rtl/gdu_pkg.sv
package gdu_pkg;

    // request codes carried in s_tuser
    localparam logic [1:0] REQ_NEXT  = 2'd0;
    localparam logic [1:0] REQ_PREV  = 2'd1;
    localparam logic [1:0] REQ_CHECK = 2'd2;
    localparam logic [1:0] REQ_DIFF  = 2'd3;

    localparam logic [14:0] YEAR_MIN = 15'd1900;
    localparam logic [14:0] YEAR_MAX = 15'd30000;
    localparam logic [15:0] YEAR_SAT = 16'd32767;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // floor(y / 100) = (y * 5243) >> 19, exact for every 15-bit y
    localparam int          DIV100_SHIFT  = 19;
    localparam logic [27:0] DIV100_MUL    = 28'd5243;

    localparam int DN_W = 24;

    typedef struct packed {
        logic [14:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } date_t;

    typedef struct packed {
        logic            ok;
        logic            leap;
        logic [DN_W-1:0] dn;
    } date_info_t;

    typedef struct packed {
        logic [DN_W-1:0] day_count;
        logic [14:0]     out_year;
        logic [3:0]      out_month;
        logic [4:0]      out_day;
        logic            valid_res;
    } result_t;

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // days from 1 March to the first of month m, in a year that starts in March
    function automatic logic [8:0] month_offset(input logic [3:0] m);
        logic [8:0] ofs;
        unique case (m)
            4'd3:    ofs = 9'd0;
            4'd4:    ofs = 9'd31;
            4'd5:    ofs = 9'd61;
            4'd6:    ofs = 9'd92;
            4'd7:    ofs = 9'd122;
            4'd8:    ofs = 9'd153;
            4'd9:    ofs = 9'd184;
            4'd10:   ofs = 9'd214;
            4'd11:   ofs = 9'd245;
            4'd12:   ofs = 9'd275;
            4'd1:    ofs = 9'd306;
            4'd2:    ofs = 9'd337;
            default: ofs = 9'd0;
        endcase
        return ofs;
    endfunction

endpackage

>>> rtl/gdu_date_eval.sv
// Two-stage date evaluation: validity, leap flag and linear day number.
module gdu_date_eval (
    input  logic                aclk,
    input  logic                en,
    input  gdu_pkg::date_t      date_in,
    output gdu_pkg::date_info_t info
);

    // stage A
    logic [27:0] prod_y;
    logic [27:0] prod_ya;
    logic [14:0] ya_next;

    gdu_pkg::date_t date_a_reg;
    logic [14:0]    ya_a_reg;
    logic [8:0]     qy_a_reg;
    logic [8:0]     qya_a_reg;
    logic [8:0]     mofs_a_reg;

    // stage B
    logic [15:0]         rem100;
    logic                leap;
    logic                ok;
    logic [4:0]          len;
    logic [23:0]         dn;
    gdu_pkg::date_info_t info_reg;

    always_comb begin
        ya_next = (date_in.month <= gdu_pkg::MONTH_FEB) ? date_in.year - 15'd1 : date_in.year;
        prod_y  = 28'(date_in.year) * gdu_pkg::DIV100_MUL;
        prod_ya = 28'(ya_next) * gdu_pkg::DIV100_MUL;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            date_a_reg <= date_in;
            ya_a_reg   <= ya_next;
            qy_a_reg   <= 9'(prod_y >> gdu_pkg::DIV100_SHIFT);
            qya_a_reg  <= 9'(prod_ya >> gdu_pkg::DIV100_SHIFT);
            mofs_a_reg <= gdu_pkg::month_offset(date_in.month);
        end
    end

    always_comb begin
        rem100 = 16'(date_a_reg.year) - 16'(qy_a_reg) * 16'd100;
        // leap: divisible by 4, and not a century unless the century count is a multiple of 4
        leap = (date_a_reg.year[1:0] == 2'b00) &&
               ((rem100 != 16'd0) || (qy_a_reg[1:0] == 2'b00));
        len  = gdu_pkg::month_days(date_a_reg.month, leap);
        ok   = (date_a_reg.year >= gdu_pkg::YEAR_MIN) && (date_a_reg.year <= gdu_pkg::YEAR_MAX) &&
               (date_a_reg.month >= gdu_pkg::MONTH_JAN) && (date_a_reg.month <= gdu_pkg::MONTH_DEC) &&
               (date_a_reg.day != 5'd0) && (date_a_reg.day <= len);
        dn   = 24'(ya_a_reg) * 24'd365 + 24'(ya_a_reg >> 2) - 24'(qya_a_reg)
             + 24'(qya_a_reg >> 2) + 24'(mofs_a_reg) + 24'(date_a_reg.day) - 24'd1;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            info_reg.ok   <= ok;
            info_reg.leap <= leap;
            info_reg.dn   <= dn;
        end
    end

    assign info = info_reg;

endmodule

>>> rtl/gregorian_date_unit_top.sv
// Gregorian date unit: next date, previous date, validity check and day
// difference on Gregorian dates (years 1900..30000).
//
// Input channel s_*: one request per transfer. s_tuser holds the request
// kind, s_tdata the first date (day, month, year) and the second date
// (other_day, other_month, other_year), used only for a difference.
// Output channel m_*: one result per request, in request order. m_tdata holds
// the resulting day, month and year (the first date echoed for a check or a
// difference) and the day count; m_tuser flags a valid date (both dates for a
// difference).
//
// Throughput: one transfer per cycle while the receiver keeps m_tready high.
// Three register stages lie between an input transfer and m_tvalid (divide
// by 100 via reciprocal multiply, day-number and leap evaluation, step and
// difference).
// Reset (aresetn low, synchronous) empties the pipeline and the skid buffer;
// s_tready stays low while aresetn is low.
// When the receiver stalls, the pending result is parked in a one-entry skid
// buffer, the pipeline freezes and s_tready drops on the next cycle; s_tready
// comes from a register, not from m_tready.
module gregorian_date_unit_top (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // day[4:0], month[8:5], year[23:9], other_day[28:24], other_month[32:29],
    // other_year[47:33]
    input  logic [47:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // out_day[4:0], out_month[8:5], out_year[23:9], day_count[47:24]
    output logic [47:0] m_tdata,
    // valid_res[0]
    output logic [0:0]  m_tuser
);

    logic en;

    gdu_pkg::date_t date_a_in;
    gdu_pkg::date_t date_b_in;

    // stage 1 and 2 echo of the first date and the request kind
    logic           v1_reg;
    logic           v2_reg;
    logic           v3_reg;
    logic [1:0]     req1_reg;
    logic [1:0]     req2_reg;
    gdu_pkg::date_t date1_reg;
    gdu_pkg::date_t date2_reg;

    gdu_pkg::date_info_t info_a;
    gdu_pkg::date_info_t info_b;

    // stage 3
    logic [4:0]       cur_len;
    logic [4:0]       prev_len;
    logic [15:0]      year_wide_next;
    gdu_pkg::result_t res_next;
    gdu_pkg::result_t res3_reg;

    // skid
    logic             skid_full_reg;
    gdu_pkg::result_t skid_reg;
    gdu_pkg::result_t res_out;

    // freeze the whole pipeline while the skid buffer holds a result
    assign en       = !skid_full_reg;
    assign s_tready = en && aresetn;

    assign date_a_in.day   = s_tdata[4:0];
    assign date_a_in.month = s_tdata[8:5];
    assign date_a_in.year  = s_tdata[23:9];
    assign date_b_in.day   = s_tdata[28:24];
    assign date_b_in.month = s_tdata[32:29];
    assign date_b_in.year  = s_tdata[47:33];

    gdu_date_eval u_eval_a (
        .aclk    (aclk),
        .en      (en),
        .date_in (date_a_in),
        .info    (info_a)
    );

    gdu_date_eval u_eval_b (
        .aclk    (aclk),
        .en      (en),
        .date_in (date_b_in),
        .info    (info_b)
    );

    // advance valid bits with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            req1_reg  <= s_tuser;
            date1_reg <= date_a_in;
            req2_reg  <= req1_reg;
            date2_reg <= date1_reg;
            res3_reg  <= res_next;
        end
    end

    // step the date or form the difference
    always_comb begin
        cur_len        = gdu_pkg::month_days(date2_reg.month, info_a.leap);
        prev_len       = gdu_pkg::month_days(date2_reg.month - 4'd1, info_a.leap);
        year_wide_next = {1'b0, date2_reg.year};
        res_next.out_day   = date2_reg.day;
        res_next.out_month = date2_reg.month;
        res_next.valid_res = info_a.ok;
        res_next.day_count = '0;
        unique case (req2_reg)
            gdu_pkg::REQ_NEXT: begin
                if (info_a.ok) begin
                    if (date2_reg.day == cur_len) begin
                        res_next.out_day = 5'd1;
                        if (date2_reg.month == gdu_pkg::MONTH_DEC) begin
                            res_next.out_month = gdu_pkg::MONTH_JAN;
                            year_wide_next     = {1'b0, date2_reg.year} + 16'd1;
                        end else begin
                            res_next.out_month = date2_reg.month + 4'd1;
                        end
                    end else begin
                        res_next.out_day = date2_reg.day + 5'd1;
                    end
                end
            end
            gdu_pkg::REQ_PREV: begin
                if (info_a.ok) begin
                    if (date2_reg.day == 5'd1) begin
                        if (date2_reg.month == gdu_pkg::MONTH_JAN) begin
                            res_next.out_day   = 5'd31;
                            res_next.out_month = gdu_pkg::MONTH_DEC;
                            year_wide_next     = {1'b0, date2_reg.year} - 16'd1;
                        end else begin
                            res_next.out_month = date2_reg.month - 4'd1;
                            res_next.out_day   = prev_len;
                        end
                    end else begin
                        res_next.out_day = date2_reg.day - 5'd1;
                    end
                end
            end
            gdu_pkg::REQ_CHECK: begin
            end
            gdu_pkg::REQ_DIFF: begin
                res_next.valid_res = info_a.ok && info_b.ok;
                if (info_a.ok && info_b.ok) begin
                    res_next.day_count = (info_a.dn > info_b.dn) ? info_a.dn - info_b.dn
                                                                 : info_b.dn - info_a.dn;
                end
            end
            default: begin
            end
        endcase
        // saturate the year
        res_next.out_year = (year_wide_next > gdu_pkg::YEAR_SAT) ? 15'(gdu_pkg::YEAR_SAT)
                                                                 : year_wide_next[14:0];
    end

    // park the stage-3 result when the receiver stalls while the pipeline moves
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_full_reg <= 1'b0;
        end else if (skid_full_reg) begin
            if (m_tready) begin
                skid_full_reg <= 1'b0;
            end
        end else if (v3_reg && !m_tready) begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_full_reg && v3_reg && !m_tready) begin
            skid_reg <= res3_reg;
        end
    end

    // the skid entry is always older than stage 3
    assign res_out  = skid_full_reg ? skid_reg : res3_reg;
    assign m_tvalid = skid_full_reg || v3_reg;
    assign m_tdata  = {res_out.day_count, res_out.out_year, res_out.out_month, res_out.out_day};
    assign m_tuser  = res_out.valid_res;

    // a nonzero count only comes from a difference of two valid dates
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res_out.day_count != '0) |-> res_out.valid_res)
        else $error("day count without valid dates");

    // a valid result always carries a real day and month
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_out.valid_res |->
            (res_out.out_day != 5'd0) && (res_out.out_month >= gdu_pkg::MONTH_JAN) &&
            (res_out.out_month <= gdu_pkg::MONTH_DEC))
        else $error("valid result with malformed date");

    // the skid buffer fills only on a stall
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg && !$past(skid_full_reg) |-> !$past(m_tready))
        else $error("skid filled without a stall");

    // a parked result stays parked, and input stays refused, while the receiver stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg && !m_tready |=> skid_full_reg && !s_tready)
        else $error("skid entry lost during stall");

endmodule

>>> bench/tb_gregorian_date_unit_top.sv
module tb_gregorian_date_unit_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Three register stages between an input transfer and m_tvalid.
    localparam int LATENCY     = 3;
    // Receiver hold-off used to fill the pipe and the skid buffer.
    localparam int LONG_HOLD   = 240;
    // Cycles without any transfer on either side before the run is abandoned.
    localparam int IDLE_LIMIT  = 3000;
    localparam int PHASE_ITEMS = 210;
    localparam int HOLD_ITEMS  = 60;
    localparam int REPORT_MAX  = 10;

    // Idle percentages per random phase: none, sender only, receiver only, both.
    localparam int unsigned SEND_IDLE  [4] = '{0, 52, 0, 17};
    localparam int unsigned RECV_STALL [4] = '{0, 0, 52, 17};

    typedef struct packed {
        logic [1:0]  op;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [14:0] year;
        logic [4:0]  other_day;
        logic [3:0]  other_month;
        logic [14:0] other_year;
    } date_req_t;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [14:0] year;
        logic        valid;
        logic [23:0] count;
    } date_answer_t;

    // One directed row: the request, and the answer where it is typed in by hand.
    typedef struct packed {
        date_req_t    req;
        logic         typed;
        date_answer_t ans;
    } plan_row_t;

    // Directed stimulus. Rows with typed = 0 are checked against the predictor.
    localparam plan_row_t PLAN [25] = '{
        // year rollover at the top of the range, and the step below the bottom
        '{'{gdu_pkg::REQ_NEXT,  31, 12, 30000,  0,  0,     0}, 1, '{ 1,  1, 30001, 1, 0}},
        '{'{gdu_pkg::REQ_PREV,   1,  1,  1900,  0,  0,     0}, 1, '{31, 12,  1899, 1, 0}},
        // invalid dates echo unchanged with valid low
        '{'{gdu_pkg::REQ_NEXT,   0,  0,     0,  0,  0,     0}, 1, '{ 0,  0,     0, 0, 0}},
        '{'{gdu_pkg::REQ_PREV,  31, 15, 32767, 31, 15, 32767}, 1, '{31, 15, 32767, 0, 0}},
        // leap rule (century not divisible by 400, century divisible by 400), then range edges and bad days
        '{'{gdu_pkg::REQ_CHECK, 29,  2,  1900,  0,  0,     0}, 1, '{29,  2,  1900, 0, 0}},
        '{'{gdu_pkg::REQ_CHECK, 29,  2,  2000,  0,  0,     0}, 1, '{29,  2,  2000, 1, 0}},
        '{'{gdu_pkg::REQ_CHECK, 31, 12, 30000,  0,  0,     0}, 1, '{31, 12, 30000, 1, 0}},
        '{'{gdu_pkg::REQ_CHECK,  1,  1, 30001,  0,  0,     0}, 1, '{ 1,  1, 30001, 0, 0}},
        '{'{gdu_pkg::REQ_CHECK,  1,  1,  1899,  0,  0,     0}, 1, '{ 1,  1,  1899, 0, 0}},
        '{'{gdu_pkg::REQ_CHECK,  0,  1,  2000,  0,  0,     0}, 1, '{ 0,  1,  2000, 0, 0}},
        '{'{gdu_pkg::REQ_CHECK, 31,  4,  2021,  0,  0,     0}, 1, '{31,  4,  2021, 0, 0}},
        // month ends, February in both kinds of year
        '{'{gdu_pkg::REQ_NEXT,  28,  2,  2023,  0,  0,     0}, 0, '0},
        '{'{gdu_pkg::REQ_NEXT,  28,  2,  2024,  0,  0,     0}, 0, '0},
        '{'{gdu_pkg::REQ_NEXT,  29,  2,  2000,  0,  0,     0}, 0, '0},
        '{'{gdu_pkg::REQ_PREV,   1,  3,  2100,  0,  0,     0}, 0, '0},
        '{'{gdu_pkg::REQ_PREV,   1,  3,  2000,  0,  0,     0}, 0, '0},
        '{'{gdu_pkg::REQ_NEXT,  30,  4,  2021,  0,  0,     0}, 0, '0},
        '{'{gdu_pkg::REQ_PREV,   1,  5,  2021,  0,  0,     0}, 0, '0},
        // second date ignored outside a difference
        '{'{gdu_pkg::REQ_NEXT,   1,  1,  2000, 31, 15, 32767}, 1, '{ 2,  1,  2000, 1, 0}},
        // differences: same date, full span both ways, across a leap day
        '{'{gdu_pkg::REQ_DIFF,   1,  1,  1900,  1,  1,  1900}, 1, '{ 1,  1,  1900, 1, 0}},
        '{'{gdu_pkg::REQ_DIFF,   1,  1,  1900, 31, 12, 30000}, 0, '0},
        '{'{gdu_pkg::REQ_DIFF,  31, 12, 30000,  1,  1,  1900}, 0, '0},
        '{'{gdu_pkg::REQ_DIFF,   1,  3,  2000, 28,  2,  2000}, 1, '{ 1,  3,  2000, 1, 2}},
        // a difference with either date invalid gives no count
        '{'{gdu_pkg::REQ_DIFF,   1,  1,  1899,  1,  1,  2000}, 1, '{ 1,  1,  1899, 0, 0}},
        '{'{gdu_pkg::REQ_DIFF,  15,  6,  2000, 31, 15, 32767}, 1, '{15,  6,  2000, 0, 0}}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = gdu_pkg::REQ_NEXT;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;

    date_answer_t answers_due [$];
    int unsigned  mismatches  = 0;
    int unsigned  idle_pct    = 0;   // sender side, used by the driving process only
    int unsigned  stall_pct   = 0;   // receiver side, written by NBA
    int unsigned  hold_orders = 0;   // bump to ask the receiver for a long hold-off
    int unsigned  quiet_cycles = 0;

    gregorian_date_unit_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------

    function automatic int unsigned month_len(int unsigned m, int unsigned y);
        bit leap;
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        case (m)
            4, 6, 9, 11:        return 30;
            gdu_pkg::MONTH_FEB: return leap ? 29 : 28;
            default:            return 31;
        endcase
    endfunction

    function automatic bit date_ok(int unsigned d, int unsigned m, int unsigned y);
        if (y < gdu_pkg::YEAR_MIN || y > gdu_pkg::YEAR_MAX ||
            m < gdu_pkg::MONTH_JAN || m > gdu_pkg::MONTH_DEC)
            return 1'b0;
        return d >= 1 && d <= month_len(m, y);
    endfunction

    // Linear day count with the year starting in March, so the leap day is last.
    function automatic int unsigned day_serial(int unsigned d, int unsigned m,
                                               int unsigned y);
        int unsigned ya;
        int unsigned doy;
        ya  = (m <= gdu_pkg::MONTH_FEB) ? y - 1 : y;
        doy = (153 * ((m + 9) % 12) + 2) / 5 + d - 1;
        return 365 * ya + ya / 4 - ya / 100 + ya / 400 + doy;
    endfunction

    function automatic date_answer_t predict_answer(date_req_t r);
        date_answer_t ans;
        int unsigned  d;
        int unsigned  m;
        int unsigned  y;
        int unsigned  a;
        int unsigned  b;
        bit           ok;
        d   = r.day;
        m   = r.month;
        y   = r.year;
        ok  = date_ok(d, m, y);
        ans = '0;
        ans.valid = ok;
        case (r.op)
            gdu_pkg::REQ_NEXT: begin
                if (ok) begin
                    if (d == month_len(m, y)) begin
                        d = 1;
                        if (m == gdu_pkg::MONTH_DEC) begin
                            m = gdu_pkg::MONTH_JAN;
                            y++;
                        end else begin
                            m++;
                        end
                    end else begin
                        d++;
                    end
                end
            end
            gdu_pkg::REQ_PREV: begin
                if (ok) begin
                    if (d == 1) begin
                        if (m == gdu_pkg::MONTH_JAN) begin
                            m = gdu_pkg::MONTH_DEC;
                            y--;
                        end else begin
                            m--;
                        end
                        d = month_len(m, y);
                    end else begin
                        d--;
                    end
                end
            end
            gdu_pkg::REQ_DIFF: begin
                ans.valid = ok && date_ok(r.other_day, r.other_month, r.other_year);
                if (ans.valid) begin
                    a = day_serial(d, m, y);
                    b = day_serial(r.other_day, r.other_month, r.other_year);
                    ans.count = 24'((a > b) ? a - b : b - a);
                end
            end
            default: ;
        endcase
        if (y > gdu_pkg::YEAR_SAT)
            y = gdu_pkg::YEAR_SAT;
        ans.day   = 5'(d);
        ans.month = 4'(m);
        ans.year  = 15'(y);
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Random requests
    // ------------------------------------------------------------------

    // Valid date biased toward range edges, centuries, leap years and month ends;
    // one pick in ten lands one day past the end of the month.
    function automatic void pick_date(output logic [4:0] d, output logic [3:0] m,
                                      output logic [14:0] y);
        int unsigned yy;
        int unsigned mm;
        int unsigned len;
        int unsigned pick;
        case ($urandom_range(4))
            0:       yy = $urandom_range(30000, 1900);
            1:       yy = $urandom_range(1930, 1900);
            2:       yy = $urandom_range(30000, 29970);
            3:       yy = 100 * $urandom_range(300, 19);
            default: yy = 4 * $urandom_range(7500, 475);
        endcase
        mm   = ($urandom_range(3) == 0) ? gdu_pkg::MONTH_FEB : $urandom_range(12, 1);
        len  = month_len(mm, yy);
        pick = $urandom_range(9);
        if (pick < 3)
            d = 5'd1;
        else if (pick < 6)
            d = 5'(len);
        else if (pick < 9)
            d = 5'($urandom_range(len, 1));
        else
            d = 5'(len + 1);
        m = 4'(mm);
        y = 15'(yy);
    endfunction

    // Mostly well-formed dates with random content; about one in seven is raw noise
    // over the full field ranges.
    function automatic date_req_t rand_request();
        date_req_t r;
        r.op          = 2'($urandom_range(3));
        r.day         = 5'($urandom_range(31));
        r.month       = 4'($urandom_range(15));
        r.year        = 15'($urandom_range(32767));
        r.other_day   = 5'($urandom_range(31));
        r.other_month = 4'($urandom_range(15));
        r.other_year  = 15'($urandom_range(32767));
        if ($urandom_range(99) >= 15)
            pick_date(r.day, r.month, r.year);
        if (r.op == gdu_pkg::REQ_DIFF && $urandom_range(99) >= 10)
            pick_date(r.other_day, r.other_month, r.other_year);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one request, idling first at random, and hold it until the transfer.
    // The answer is queued at the accepting edge: typed in, or predicted.
    task automatic offer_request(input date_req_t r, input bit typed,
                                 input date_answer_t given);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        // other_year, other_month, other_day, year, month, day from the top down
        s_tdata  <= {r.other_year, r.other_month, r.other_day, r.year, r.month, r.day};
        do
            @(posedge aclk);
        while (!s_tready);
        answers_due.push_back(typed ? given : predict_answer(r));
    endtask

    // Drop valid and wait until every queued answer has been seen.
    task automatic wait_answers_in();
        s_tvalid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Output side: check each transfer, then decide the next m_tready
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : result_side
        date_answer_t got;
        date_answer_t want;
        int unsigned  hold_left;
        int unsigned  hold_served;
        bit           bad;

        if (aresetn && m_tvalid && m_tready) begin
            got.day   = m_tdata[4:0];
            got.month = m_tdata[8:5];
            got.year  = m_tdata[23:9];
            got.count = m_tdata[47:24];
            got.valid = m_tuser[0];
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: day %0d month %0d year %0d valid %0d count %0d",
                             got.day, got.month, got.year, got.valid, got.count);
            end else begin
                want = answers_due.pop_front();
                bad  = (got.day !== want.day) || (got.month !== want.month) ||
                       (got.year !== want.year) || (got.valid !== want.valid) ||
                       (got.count !== want.count);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("mismatch: want %0d/%0d/%0d v%0d n%0d, got %0d/%0d/%0d v%0d n%0d",
                                 want.day, want.month, want.year, want.valid, want.count,
                                 got.day, got.month, got.year, got.valid, got.count);
                end
            end
        end

        // A new hold order starts a long hold-off; otherwise stall at random.
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_served != hold_orders) begin
            hold_served = hold_orders;
            hold_left   = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: give up after too many cycles with no transfer on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        // Hold reset low, then release it at an edge.
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table with both sides running flat out.
        foreach (PLAN[i])
            offer_request(PLAN[i].req, PLAN[i].typed, PLAN[i].ans);
        wait_answers_in();

        // Random phases; the sender pauses at the end of each until all results are in.
        for (int p = 0; p < 4; p++) begin
            idle_pct = SEND_IDLE[p];
            stall_pct <= RECV_STALL[p];
            repeat (PHASE_ITEMS)
                offer_request(rand_request(), 1'b0, '0);
            wait_answers_in();
        end

        // Long receiver hold-off while the sender keeps offering: fill the pipe and
        // the skid buffer, and see s_tready drop and recover.
        idle_pct = 0;
        stall_pct <= 0;
        hold_orders <= hold_orders + 1;
        repeat (HOLD_ITEMS)
            offer_request(rand_request(), 1'b0, '0);
        wait_answers_in();

        if (mismatches == 0 && answers_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/gdu_pkg.sv
rtl/gdu_date_eval.sv
rtl/gregorian_date_unit_top.sv
bench/tb_gregorian_date_unit_top.sv
